// ===== rtl/mpts_pkg.sv =====
// Shared types and constants of the memory pattern test sequencer.
package mpts_pkg;

    // Field widths
    localparam int BUS_ADDR_W = 16;
    localparam int FIRST_W    = 16;
    localparam int END_W      = 17;
    localparam int DATA_W     = 8;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    // Default address space width
    localparam int ADDRESS_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [FIRST_W-1:0] FIRST_ADDRESS_RST = 16'h4000;
    localparam logic [END_W-1:0]   END_ADDRESS_RST   = 17'h0C000;

    // Running pattern
    localparam logic [DATA_W-1:0] PATTERN_INIT = 8'h01;
    localparam logic [DATA_W-1:0] PATTERN_STEP = 8'h02;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ADDRESS   = 1'b1;

    // Bus access kinds
    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } acc_kind_t;

    // One result item
    typedef struct packed {
        acc_kind_t               access_kind;
        logic [BUS_ADDR_W-1:0]   bus_address;
        logic [DATA_W-1:0]       write_data;
        logic                    busy_res;
        logic                    done_res;
        logic                    failed;
        logic [BUS_ADDR_W-1:0]   fail_address;
    } mpts_result_t;

endpackage

// ===== rtl/memory_pattern_test_sequencer_top.sv =====
// Top level of the memory pattern test sequencer.
//
// Drives a three-pass byte test (write pattern; read, check, write complement;
// read, check complement) over first_address up to end_address.
// Input channel (in_valid/in_ready): start_req=1 while idle or done starts a
// test; any other item reports completion of the last access, with read_data.
// Output channel (out_valid/out_ready): one item per input item with the next
// bus access (access_kind, bus_address, write_data) and the test status.
// Accepted items are formed combinationally by a single state update and
// registered in the output register, or in the skid register while a result
// waits. Throughput: one item per cycle while in_ready is high.
// Stall: a two-entry output buffer takes one more item while a result waits;
// in_ready drops only when both entries are full.
// Configuration: cfg_we writes first_address (index 0) or end_address
// (index 1) at the clock edge; write only while no test item is in flight.
// Reset: registers return to 0x4000 and 0xC000, the sequencer goes idle with
// pattern 1 and the fail flag clear, and the output buffer empties.
module memory_pattern_test_sequencer_top #(
    parameter int ADDRESS_WIDTH = mpts_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               start_req,
    input  logic [mpts_pkg::DATA_W-1:0]        read_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         access_kind,
    output logic [mpts_pkg::BUS_ADDR_W-1:0]    bus_address,
    output logic [mpts_pkg::DATA_W-1:0]        write_data,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               failed,
    output logic [mpts_pkg::BUS_ADDR_W-1:0]    fail_address,
    input  logic                               cfg_we,
    input  logic [mpts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mpts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mpts_pkg::*;

    logic [FIRST_W-1:0] first_address_reg;
    logic [END_W-1:0]   end_address_reg;
    logic               accept;
    mpts_result_t       core_result;
    mpts_result_t       buf_result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_address_reg <= FIRST_ADDRESS_RST;
            end_address_reg   <= END_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_ADDRESS: first_address_reg <= cfg_data[FIRST_W-1:0];
                CFG_END_ADDRESS:   end_address_reg   <= cfg_data[END_W-1:0];
                default:           ;
            endcase
        end
    end

    assign accept = in_valid && in_ready;

    mpts_core #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .start_req     (start_req),
        .read_data     (read_data),
        .first_address (first_address_reg),
        .end_address   (end_address_reg),
        .result        (core_result)
    );

    mpts_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_result  (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (buf_result)
    );

    // Unpack the result item onto the ports
    assign access_kind  = buf_result.access_kind;
    assign bus_address  = buf_result.bus_address;
    assign write_data   = buf_result.write_data;
    assign busy_res     = buf_result.busy_res;
    assign done_res     = buf_result.done_res;
    assign failed       = buf_result.failed;
    assign fail_address = buf_result.fail_address;

endmodule

// ===== rtl/mpts_core.sv =====
// Test sequencer state machine: pass control, address walk, pattern and check.
module mpts_core #(
    parameter int ADDRESS_WIDTH = mpts_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            start_req,
    input  logic [mpts_pkg::DATA_W-1:0]     read_data,
    input  logic [mpts_pkg::FIRST_W-1:0]    first_address,
    input  logic [mpts_pkg::END_W-1:0]      end_address,
    output mpts_pkg::mpts_result_t          result
);
    import mpts_pkg::*;

    // Address counter must hold the saturated end address
    localparam int CW = (ADDRESS_WIDTH + 1 > END_W) ? ADDRESS_WIDTH + 1 : END_W;
    localparam logic [CW-1:0] ADDR_LIMIT = CW'(1) << ADDRESS_WIDTH;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_W1   = 3'd1,
        PH_R2   = 3'd2,
        PH_W2   = 3'd3,
        PH_R3   = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [CW-1:0]          cur_reg, cur_next;
    logic [DATA_W-1:0]      pat_reg, pat_next;
    logic                   fail_reg, fail_next;
    logic [BUS_ADDR_W-1:0]  ffa_reg, ffa_next;

    logic [CW-1:0]          first_ext;
    logic [CW-1:0]          end_ext;
    logic [CW-1:0]          eff_first;
    logic [CW-1:0]          eff_end;
    logic [CW-1:0]          adv_addr;
    logic                   adv_in_range;
    logic                   first_in_range;
    logic                   mismatch;

    // Clip the range to the address space
    assign first_ext      = CW'(first_address);
    assign end_ext        = CW'(end_address);
    assign eff_first      = first_ext & (ADDR_LIMIT - CW'(1));
    assign eff_end        = (end_ext > ADDR_LIMIT) ? ADDR_LIMIT : end_ext;
    assign adv_addr       = cur_reg + CW'(1);
    assign adv_in_range   = adv_addr < eff_end;
    assign first_in_range = eff_first < eff_end;

    // Compare read data against the expected byte of this pass
    always_comb
    begin
        mismatch = 1'b0;
        if (phase_reg == PH_R2)
        begin
            mismatch = read_data != pat_reg;
        end
        else if (phase_reg == PH_R3)
        begin
            mismatch = read_data != ~pat_reg;
        end
    end

    // Next state for one item
    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        pat_next   = pat_reg;
        fail_next  = fail_reg;
        ffa_next   = ffa_reg;

        // Record the first mismatch only
        if (mismatch && !fail_reg)
        begin
            fail_next = 1'b1;
            ffa_next  = cur_reg[BUS_ADDR_W-1:0];
        end

        unique case (phase_reg) inside
            PH_IDLE, PH_DONE:
            begin
                if (start_req)
                begin
                    fail_next  = 1'b0;
                    ffa_next   = '0;
                    pat_next   = PATTERN_INIT;
                    cur_next   = eff_first;
                    phase_next = first_in_range ? PH_W1 : PH_DONE;
                end
            end
            PH_W1:
            begin
                pat_next = pat_reg + PATTERN_STEP;
                cur_next = adv_addr;
                if (!adv_in_range)
                begin
                    cur_next   = eff_first;
                    phase_next = first_in_range ? PH_R2 : PH_DONE;
                end
            end
            PH_R2:
            begin
                phase_next = PH_W2;
            end
            PH_W2:
            begin
                pat_next = pat_reg + PATTERN_STEP;
                cur_next = adv_addr;
                if (adv_in_range)
                begin
                    phase_next = PH_R2;
                end
                else
                begin
                    cur_next   = eff_first;
                    phase_next = first_in_range ? PH_R3 : PH_DONE;
                end
            end
            PH_R3:
            begin
                pat_next = pat_reg + PATTERN_STEP;
                cur_next = adv_addr;
                if (!adv_in_range)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Build the result item from the new state
    always_comb
    begin
        result = '0;
        unique case (phase_next) inside
            PH_W1:
            begin
                result.access_kind = ACC_WRITE;
                result.write_data  = pat_next;
            end
            PH_W2:
            begin
                result.access_kind = ACC_WRITE;
                result.write_data  = ~pat_next;
            end
            PH_R2, PH_R3:
            begin
                result.access_kind = ACC_READ;
            end
            default:
            begin
                result.access_kind = ACC_NONE;
            end
        endcase
        if (result.access_kind != ACC_NONE)
        begin
            result.bus_address = cur_next[BUS_ADDR_W-1:0];
        end
        result.busy_res     = (phase_next == PH_W1) || (phase_next == PH_R2) ||
                              (phase_next == PH_W2) || (phase_next == PH_R3);
        result.done_res     = phase_next == PH_DONE;
        result.failed       = fail_next;
        result.fail_address = ffa_next;
    end

    // Hold state; advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cur_reg   <= '0;
            pat_reg   <= PATTERN_INIT;
            fail_reg  <= 1'b0;
            ffa_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            pat_reg   <= pat_next;
            fail_reg  <= fail_next;
            ffa_reg   <= ffa_next;
        end
    end

endmodule

// ===== rtl/mpts_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
module mpts_out_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  mpts_pkg::mpts_result_t  in_result,
    output logic                    out_valid,
    input  logic                    out_ready,
    output mpts_pkg::mpts_result_t  out_result
);
    import mpts_pkg::*;

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    mpts_result_t main_data_reg;
    mpts_result_t skid_data_reg;
    logic         push;
    logic         pop;

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_result = main_data_reg;
    assign push       = in_valid && in_ready;
    assign pop        = main_valid_reg && out_ready;

    // Occupancy of both entries
    always_comb
    begin
        if (skid_valid_reg)
        begin
            main_valid_next = 1'b1;
            skid_valid_next = !pop;
        end
        else
        begin
            main_valid_next = push || (main_valid_reg && !pop);
            skid_valid_next = push && main_valid_reg && !pop;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Move item data; skid drains into the output register first
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_data_reg <= skid_data_reg;
        end
        else if (push && (!main_valid_reg || pop))
        begin
            main_data_reg <= in_result;
        end
        if (push && main_valid_reg && !pop)
        begin
            skid_data_reg <= in_result;
        end
    end

endmodule

// ===== rtl/mpts_checker.sv =====
// Port-level checks of the memory pattern test sequencer, bound to the top level.
module mpts_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         access_kind,
    input logic [mpts_pkg::BUS_ADDR_W-1:0]    bus_address,
    input logic [mpts_pkg::DATA_W-1:0]        write_data,
    input logic                               busy_res,
    input logic                               done_res,
    input logic                               failed,
    input logic [mpts_pkg::BUS_ADDR_W-1:0]    fail_address
);
    import mpts_pkg::*;

    // A stalled item holds access kind, bus address, write data and fail address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(access_kind) &&
        $stable(bus_address) && $stable(write_data) && $stable(fail_address))
        else $error("stalled result item changed");

    // Busy and done never show together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(busy_res && done_res))
        else $error("busy and done both set");

    // A bus access is issued exactly while a test runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((access_kind != ACC_NONE) == busy_res))
        else $error("access kind disagrees with busy");

    // No access means a quiet bus
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (access_kind != ACC_WRITE) |-> (write_data == '0) &&
        ((access_kind != ACC_NONE) || (bus_address == '0)))
        else $error("bus driven without an access");

    // Fail address is only reported with the fail flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !failed |-> fail_address == '0)
        else $error("fail address without fail flag");

endmodule

bind memory_pattern_test_sequencer_top mpts_checker u_mpts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .access_kind  (access_kind),
    .bus_address  (bus_address),
    .write_data   (write_data),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .failed       (failed),
    .fail_address (fail_address)
);
